/* rtl/vco_coarse_tune_search_assert.svh */
// Assertion macros for the VCO coarse-tune search sequencer.
`ifndef VCO_COARSE_TUNE_SEARCH_ASSERT_SVH
`define VCO_COARSE_TUNE_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every clock edge outside reset.
`define VCTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define VCTS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define VCTS_ASSERT(lbl, prop, msg)
`define VCTS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

/* rtl/vcts_pkg.sv */
// Constants and codes shared by the VCO coarse-tune search sequencer.
package vcts_pkg;

    localparam int STEPS_PER_SEGMENT = 6;

    // Input operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_MEAS  = 1'b1;

    // Sequencer phases
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_WAIT63 = 2'd1;
    localparam logic [1:0] PH_WAIT64 = 2'd2;
    localparam logic [1:0] PH_SEARCH = 2'd3;

    // Configuration register indexes
    localparam logic CFG_TXRX = 1'b0;
    localparam logic CFG_PLL  = 1'b1;

    localparam logic [15:0] TXRX_RESET = 16'h3FFC;
    localparam logic [15:0] PLL_RESET  = 16'h0838;

    // Transceiver words
    localparam logic [9:0]  ERR_INIT   = 10'h1FF;
    localparam logic [15:0] VCO2_BASE  = 16'h2000;
    localparam logic [15:0] VCO2_CT63  = 16'h203F;
    localparam logic [15:0] VCO2_CT64  = 16'h2040;
    localparam logic [15:0] VCO1_FT0   = 16'h8000;
    localparam logic [15:0] PLL_B_WORD = 16'h1A1B;
    localparam logic [15:0] TX_ON_BIT  = 16'h0800;
    localparam logic [7:0]  BEST_RESET = 8'h4D;

    // Segment bases and span
    localparam logic [7:0] BASE_ABOVE = 8'd16;
    localparam logic [7:0] BASE_MID   = 8'd48;
    localparam logic [7:0] BASE_BELOW = 8'd80;
    localparam logic [7:0] SEG_SPAN   = 8'd16;
    localparam logic [3:0] STEP_INIT  = 4'd8;

    // Setup burst after a start word
    localparam int          SETUP_WORDS = 5;
    localparam logic [2:0]  SETUP_LAST  = 3'(SETUP_WORDS - 1);

endpackage

/* rtl/vco_coarse_tune_search.sv */
// VCO coarse-tune search sequencer: setup burst, segment choice, SAR search.
//
//  channel  direction  handshake                    payload
//  input    in         i_valid / o_stall            i_op i_ref_voltage i_voltage i_locked
//  output   out        o_valid / i_stall            o_spi_word o_done_res o_best_coarse o_last
//  config   in         i_cfg_valid / o_cfg_ready    i_cfg_index i_cfg_data
//
// Each input word is processed in the cycle it is accepted; its results appear
// in the output register on the next cycle. A start word gives five results,
// one per cycle unless stalled, read out of the output register by an index
// counter; every other word gives at most one. A new input word is taken in the
// same cycle that the last result of the previous one leaves, so one word per
// cycle is sustained while results are single and unstalled. Reset is synchronous,
// active low, and clears all sequencer state; the config port is always ready.
module vco_coarse_tune_search (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [9:0]  i_ref_voltage,
    input  logic [9:0]  i_voltage,
    input  logic        i_locked,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_spi_word,
    output logic        o_done_res,
    output logic [7:0]  o_best_coarse,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import vcts_pkg::*;

`include "vco_coarse_tune_search_assert.svh"

    // Configuration
    logic [15:0] r_txrx_word;
    logic [15:0] r_pll_word;

    // Sequencer state
    logic [1:0] r_phase,      n_phase;
    logic       r_seg_index,  n_seg_index;
    logic [2:0] r_step_count, n_step_count;
    logic [7:0] r_coarse,     n_coarse;
    logic [3:0] r_code_step,  n_code_step;
    logic [7:0] r_seg_end,    n_seg_end;
    logic [9:0] r_v63,        n_v63;
    logic [9:0] r_reference,  n_reference;
    logic [9:0] r_min_err,    n_min_err;
    logic [7:0] r_cand_code,  n_cand_code;
    logic [7:0] r_cand_dist,  n_cand_dist;
    logic [7:0] r_best_dist,  n_best_dist;
    logic [7:0] r_best_code,  n_best_code;

    // Output register
    logic        r_valid;
    logic        r_setup;
    logic [2:0]  r_idx;
    logic [15:0] r_word;
    logic        r_done;
    logic [7:0]  r_best;

    logic        n_has_res;
    logic [15:0] n_res_word;
    logic        n_res_done;

    logic        out_fire;
    logic        out_last;
    logic        in_ready;
    logic        in_fire;

    logic [9:0]  err;
    logic [7:0]  seg_dist;
    logic [7:0]  stepped;
    logic [7:0]  base;
    logic        more_steps;
    logic [15:0] setup_word;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_txrx_word <= TXRX_RESET;
            r_pll_word  <= PLL_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TXRX: r_txrx_word <= i_cfg_data;
                CFG_PLL:  r_pll_word  <= i_cfg_data;
                default:  r_pll_word  <= r_pll_word;
            endcase
        end
    end

    assign out_fire = r_valid && !i_stall;
    assign out_last = r_setup ? (r_idx == SETUP_LAST) : 1'b1;
    assign in_ready = !r_valid || (out_fire && out_last);
    assign in_fire  = i_valid && in_ready;
    assign o_stall  = !in_ready;

    assign err     = (i_voltage >= r_reference) ? (i_voltage - r_reference)
                                                : (r_reference - i_voltage);
    assign seg_dist = (r_coarse > r_seg_end) ? (r_coarse - r_seg_end)
                                             : (r_seg_end - r_coarse);
    assign stepped = (i_voltage < r_reference) ? (r_coarse + {4'd0, r_code_step})
                                               : (r_coarse - {4'd0, r_code_step});
    assign more_steps = ({1'b0, r_step_count} + 4'd1) < 4'(STEPS_PER_SEGMENT);

    always_comb begin
        if (r_v63 < r_reference && i_voltage < r_reference) begin
            base = BASE_BELOW;
        end else if (r_v63 > r_reference && i_voltage > r_reference) begin
            base = BASE_ABOVE;
        end else begin
            base = BASE_MID;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_seg_index  = r_seg_index;
        n_step_count = r_step_count;
        n_coarse     = r_coarse;
        n_code_step  = r_code_step;
        n_seg_end    = r_seg_end;
        n_v63        = r_v63;
        n_reference  = r_reference;
        n_min_err    = r_min_err;
        n_cand_code  = r_cand_code;
        n_cand_dist  = r_cand_dist;
        n_best_dist  = r_best_dist;
        n_best_code  = r_best_code;
        n_has_res    = 1'b0;
        n_res_word   = 16'd0;
        n_res_done   = 1'b0;

        if (i_op == OP_START) begin
            n_reference = i_ref_voltage;
            n_min_err   = ERR_INIT;
            n_cand_code = 8'd0;
            n_cand_dist = 8'd0;
            n_best_dist = 8'd0;
            n_seg_index = 1'b0;
            n_phase     = PH_WAIT63;
            n_has_res   = 1'b1;
        end else begin
            unique case (r_phase)
                PH_WAIT63: begin
                    n_v63      = i_voltage;
                    n_phase    = PH_WAIT64;
                    n_has_res  = 1'b1;
                    n_res_word = VCO2_CT64;
                end
                PH_WAIT64: begin
                    n_seg_end    = base + SEG_SPAN;
                    n_seg_index  = 1'b0;
                    n_coarse     = base;
                    n_code_step  = STEP_INIT;
                    n_step_count = 3'd0;
                    n_phase      = PH_SEARCH;
                    n_has_res    = 1'b1;
                    n_res_word   = VCO2_BASE | {8'd0, base};
                end
                PH_SEARCH: begin
                    if (i_locked && err < r_min_err) begin
                        n_min_err   = err;
                        n_cand_code = r_coarse;
                        n_cand_dist = seg_dist;
                    end
                    n_coarse    = stepped;
                    n_code_step = (r_code_step > 4'd1) ? (r_code_step >> 1) : r_code_step;
                    n_has_res   = 1'b1;
                    if (more_steps) begin
                        n_step_count = r_step_count + 3'd1;
                        n_res_word   = VCO2_BASE | {8'd0, stepped};
                    end else begin
                        n_min_err = ERR_INIT;
                        if (n_cand_dist > r_best_dist) begin
                            n_best_dist = n_cand_dist;
                            n_best_code = n_cand_code;
                        end
                        if (!r_seg_index) begin
                            // second segment starts one span past the first one's end
                            n_seg_index  = 1'b1;
                            n_coarse     = r_seg_end + SEG_SPAN;
                            n_code_step  = STEP_INIT;
                            n_step_count = 3'd0;
                            n_res_word   = VCO2_BASE | {8'd0, r_seg_end + SEG_SPAN};
                        end else begin
                            n_phase      = PH_IDLE;
                            n_step_count = 3'd0;
                            n_res_done   = 1'b1;
                        end
                    end
                end
                default: begin
                    // measurement while idle: drop
                    n_has_res = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_seg_index  <= 1'b0;
            r_step_count <= 3'd0;
            r_coarse     <= 8'd0;
            r_code_step  <= STEP_INIT;
            r_seg_end    <= 8'd0;
            r_v63        <= 10'd0;
            r_reference  <= 10'd0;
            r_min_err    <= ERR_INIT;
            r_cand_code  <= 8'd0;
            r_cand_dist  <= 8'd0;
            r_best_dist  <= 8'd0;
            r_best_code  <= BEST_RESET;
        end else if (in_fire) begin
            r_phase      <= n_phase;
            r_seg_index  <= n_seg_index;
            r_step_count <= n_step_count;
            r_coarse     <= n_coarse;
            r_code_step  <= n_code_step;
            r_seg_end    <= n_seg_end;
            r_v63        <= n_v63;
            r_reference  <= n_reference;
            r_min_err    <= n_min_err;
            r_cand_code  <= n_cand_code;
            r_cand_dist  <= n_cand_dist;
            r_best_dist  <= n_best_dist;
            r_best_code  <= n_best_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_setup <= 1'b0;
            r_idx   <= 3'd0;
        end else if (in_fire) begin
            r_valid <= n_has_res;
            r_setup <= (i_op == OP_START);
            r_idx   <= 3'd0;
        end else if (out_fire) begin
            if (out_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_word <= n_res_word;
            r_done <= n_res_done;
            r_best <= n_best_code;
        end
    end

    always_comb begin
        unique case (r_idx)
            3'd0:    setup_word = r_pll_word;
            3'd1:    setup_word = PLL_B_WORD;
            3'd2:    setup_word = VCO1_FT0;
            3'd3:    setup_word = VCO2_CT63;
            default: setup_word = r_txrx_word & ~TX_ON_BIT;
        endcase
    end

    assign o_valid       = r_valid;
    assign o_spi_word    = r_setup ? setup_word : r_word;
    assign o_done_res    = r_setup ? 1'b0 : r_done;
    assign o_best_coarse = r_best;
    assign o_last        = out_last;

    `VCTS_ASSERT(a_hold_input_mid_burst, (o_valid && !o_last) |-> o_stall, "input taken mid-burst")
    `VCTS_ASSERT(a_done_word_zero,
                 (o_valid && o_done_res) |-> (o_spi_word == 16'd0 && o_last),
                 "done result carries a word")
    `VCTS_ASSERT(a_setup_index_range, r_setup |-> (r_idx <= SETUP_LAST), "setup index out of range")
    `VCTS_ASSERT(a_start_to_wait63,
                 (in_fire && i_op == OP_START) |=> (r_phase == PH_WAIT63 && o_valid),
                 "start did not arm search")

endmodule
